[design/gei_pkg.sv]
// Shared types, constants and lookup tables for the expected improvement pipeline
package gei_pkg;

	localparam int ZF          = 20;
	localparam int QB          = 28;
	localparam int TAB_LEN     = 76;
	localparam int CDF_ENTRIES = 76;
	localparam int DEN_LAST    = 75;
	localparam int FAR_IDX     = 127;

	typedef logic [30:0] tab_t;
	typedef longint unsigned nano_arr_t [TAB_LEN];
	typedef tab_t tab_arr_t [TAB_LEN];

	localparam tab_t ONE_Q = 31'h4000_0000;

	localparam nano_arr_t CDF_NANO = '{
		500000000, 539827837, 579259709, 617911422, 655421742, 691462461, 725746882,
		758036348, 788144601, 815939875, 841344746, 864333939, 884930330, 903199515,
		919243341, 933192799, 945200708, 955434537, 964069681, 971283440, 977249868,
		982135579, 986096552, 989275890, 991802464, 993790335, 995338812, 996533026,
		997444870, 998134187, 998650102, 999032397, 999312862, 999516576, 999663071,
		999767371, 999840891, 999892200, 999927652, 999951904, 999968329, 999979342,
		999986654, 999991460, 999994587, 999996602, 999997888, 999998699, 999999207,
		999999521, 999999713, 999999830, 999999900, 999999942, 999999967, 999999981,
		999999989, 999999994, 999999997, 999999998, 999999999, 999999999, 1000000000,
		1000000000, 1000000000, 1000000000, 1000000000, 1000000000, 1000000000,
		1000000000, 1000000000, 1000000000, 1000000000, 1000000000, 1000000000,
		1000000000
	};

	localparam nano_arr_t DEN_NANO = '{
		398942280, 396952547, 391042694, 381387815, 368270140, 352065327, 333224603,
		312253933, 289691553, 266085250, 241970725, 217852177, 194186055, 171368592,
		149727466, 129517596, 110920835, 94049077, 78950158, 65615815, 53990967,
		43983596, 35474593, 28327038, 22394530, 17528300, 13582969, 10420935,
		7915452, 5952532, 4431848, 3266819, 2384088, 1722569, 1232219, 872683,
		611902, 424780, 291947, 198655, 133830, 89262, 58943, 38535, 24942, 15984,
		10141, 6370, 3961, 2439, 1487, 897, 536, 317, 186, 108, 62, 35, 20, 11,
		6, 3, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
	};

	// nano units to Q30, round half up; evaluated at elaboration only
	function automatic tab_arr_t to_q(nano_arr_t n);
		tab_arr_t        r;
		longint unsigned v;
		for (int i = 0; i < TAB_LEN; i++) begin
			v = (n[i] * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
			r[i] = v[30:0];
		end
		return r;
	endfunction

	localparam tab_arr_t CDF_Q = to_q(CDF_NANO);
	localparam tab_arr_t DEN_Q = to_q(DEN_NANO);

	function automatic tab_t cdf_at(logic [7:0] i);
		tab_t r;
		if (i < 8'(TAB_LEN)) r = CDF_Q[i[6:0]];
		else r = ONE_Q;
		return r;
	endfunction

	function automatic tab_t den_at(logic [7:0] i);
		tab_t r;
		if (i < 8'(TAB_LEN)) r = DEN_Q[i[6:0]];
		else r = '0;
		return r;
	endfunction

	typedef struct packed {
		logic               spread0;
		logic               neg;
		logic               far7;
		logic               far13;
		logic signed [32:0] d;
		logic signed [31:0] s;
	} gei_side_t;

endpackage

[design/gei_if.sv]
// Handshake interfaces for the input and result words
interface gei_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] prediction;
	logic signed [31:0] best_value;
	logic signed [31:0] deviation;

	modport source(output valid, prediction, best_value, deviation, input ready);
	modport sink(input valid, prediction, best_value, deviation, output ready);
endinterface

interface gei_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] improvement;
	logic               no_spread;

	modport source(output valid, improvement, no_spread, input ready);
	modport sink(input valid, improvement, no_spread, output ready);
endinterface

[design/gei_front.sv]
// Front stages: difference, magnitude, range flags and divider setup
module gei_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic signed [31:0]    prediction,
	input  logic signed [31:0]    best_value,
	input  logic signed [31:0]    deviation,
	output logic                  valid,
	output gei_pkg::gei_side_t    side,
	output logic [31:0]           rem0,
	output logic [gei_pkg::QB-1:0] nlow
);
	import gei_pkg::*;

	logic               v_s1, v_s2;
	logic signed [32:0] d_s1;
	logic signed [31:0] s_s1;
	logic               sp_s1;
	gei_side_t          side_s2;
	logic [31:0]        rem_s2;
	logic [QB-1:0]      nlow_s2;

	logic [32:0] mag;
	logic [36:0] mag10;
	logic [36:0] s13, s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= {best_value[31], best_value} - {prediction[31], prediction};
			s_s1  <= deviation;
			sp_s1 <= deviation[31] || (deviation == 32'sd0);
		end
	end

	always_comb begin
		mag   = d_s1[32] ? 33'(-d_s1) : 33'(d_s1);
		mag10 = ({4'b0, mag} << 3) + ({4'b0, mag} << 1);
		s13   = 37'({6'b0, s_s1[30:0]}) * 37'd13;
		s7    = 37'({6'b0, s_s1[30:0]}) * 37'd7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.spread0 <= sp_s1;
			side_s2.neg     <= d_s1[32];
			side_s2.far7    <= {4'b0, mag} > s7;
			side_s2.far13   <= {4'b0, mag} > s13;
			side_s2.d       <= d_s1;
			side_s2.s       <= s_s1;
			rem_s2          <= {3'b0, mag10[36:8]};
			nlow_s2         <= {mag10[7:0], {(QB-8){1'b0}}};
		end
	end

	assign valid = v_s2;
	assign side  = side_s2;
	assign rem0  = rem_s2;
	assign nlow  = nlow_s2;
endmodule

[design/gei_div.sv]
// Restoring divider, one quotient bit per pipeline stage
module gei_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  gei_pkg::gei_side_t     in_side,
	input  logic [31:0]            rem0,
	input  logic [gei_pkg::QB-1:0] nlow,
	output logic                   valid,
	output gei_pkg::gei_side_t     side,
	output logic [gei_pkg::QB-1:0] quo
);
	import gei_pkg::*;

	logic      v_q    [QB+1];
	gei_side_t side_q [QB+1];
	logic [31:0]   r_q [QB+1];
	logic [QB-1:0] n_q [QB+1];
	logic [QB-1:0] q_q [QB+1];

	assign v_q[0]    = in_valid;
	assign side_q[0] = in_side;
	assign r_q[0]    = rem0;
	assign n_q[0]    = nlow;
	assign q_q[0]    = '0;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [32:0] rs;
		logic        ge;
		logic [32:0] diff;

		always_comb begin
			rs   = {r_q[k], n_q[k][QB-1]};
			ge   = rs >= {2'b0, side_q[k].s[30:0]};
			diff = rs - {2'b0, side_q[k].s[30:0]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else if (en) v_q[k+1] <= v_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k+1] <= side_q[k];
				r_q[k+1]    <= ge ? diff[31:0] : rs[31:0];
				n_q[k+1]    <= n_q[k] << 1;
				q_q[k+1]    <= {q_q[k][QB-2:0], ge};
			end
		end
	end

	assign valid = v_q[QB];
	assign side  = side_q[QB];
	assign quo   = q_q[QB];
endmodule

[design/gei_lut.sv]
// Table reads and linear interpolation of the normal CDF and density
module gei_lut #(
	parameter int CDF_ENTRIES = gei_pkg::CDF_ENTRIES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  gei_pkg::gei_side_t     in_side,
	input  logic [gei_pkg::QB-1:0] quo,
	output logic                   valid,
	output gei_pkg::gei_side_t     side,
	output gei_pkg::tab_t          cdf,
	output gei_pkg::tab_t          den
);
	import gei_pkg::*;

	localparam tab_t CDF_LIM = cdf_at(8'(CDF_ENTRIES - 1));

	logic [7:0]      idx;
	logic [ZF-1:0]   frac;

	logic               v_a, v_b, v_c;
	gei_side_t          side_a, side_b, side_c;
	tab_t               ca_a, da_a, ca_b, da_b;
	logic signed [31:0] dc_a, dd_a;
	logic [ZF-1:0]      frac_a;
	logic               lim_a, end_a, lim_b, end_b;
	logic signed [52:0] pc_b, pd_b;
	tab_t               cdf_c, den_c;

	logic signed [53:0] ic, id;
	tab_t               cm, dm;

	always_comb begin
		idx  = side_b.far13 ? 8'(FAR_IDX) : 8'(0);
		frac = '0;
		if (!in_side.far13) begin
			idx  = quo[QB-1:ZF];
			frac = quo[ZF-1:0];
		end else begin
			idx = 8'(FAR_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
			v_b <= 1'b0;
			v_c <= 1'b0;
		end else if (en) begin
			v_a <= in_valid;
			v_b <= v_a;
			v_c <= v_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_a <= in_side;
			ca_a   <= cdf_at(idx);
			da_a   <= den_at(idx);
			dc_a   <= $signed({1'b0, cdf_at(idx + 8'd1)}) - $signed({1'b0, cdf_at(idx)});
			dd_a   <= $signed({1'b0, den_at(idx + 8'd1)}) - $signed({1'b0, den_at(idx)});
			frac_a <= frac;
			lim_a  <= idx >= 8'(CDF_ENTRIES - 1);
			end_a  <= idx >= 8'(DEN_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_b <= side_a;
			ca_b   <= ca_a;
			da_b   <= da_a;
			lim_b  <= lim_a;
			end_b  <= end_a;
			pc_b   <= 53'(dc_a * $signed({1'b0, frac_a}));
			pd_b   <= 53'(dd_a * $signed({1'b0, frac_a}));
		end
	end

	always_comb begin
		ic = $signed({3'b0, ca_b, {ZF{1'b0}}}) + 54'(pc_b);
		id = $signed({3'b0, da_b, {ZF{1'b0}}}) + 54'(pd_b);
		cm = lim_b ? CDF_LIM : ic[ZF+30:ZF];
		dm = end_b ? '0 : id[ZF+30:ZF];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_c <= side_b;
			den_c  <= dm;
			if (side_b.far7) cdf_c <= side_b.neg ? '0 : ONE_Q;
			else cdf_c <= side_b.neg ? ONE_Q - cm : cm;
		end
	end

	assign valid = v_c;
	assign side  = side_c;
	assign cdf   = cdf_c;
	assign den   = den_c;
endmodule

[design/gei_comb.sv]
// Final products, sum, rounding and saturation into the output register
module gei_comb (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  gei_pkg::gei_side_t in_side,
	input  gei_pkg::tab_t      cdf,
	input  gei_pkg::tab_t      den,
	output logic               valid,
	output logic signed [31:0] improvement,
	output logic               no_spread
);
	import gei_pkg::*;

	logic               v_d, v_e;
	logic               sp_d;
	logic signed [63:0] pd_d, ps_d;
	logic signed [31:0] imp_e;
	logic               sp_e;

	logic signed [63:0] acc;
	logic signed [33:0] rr;
	logic signed [31:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d <= 1'b0;
			v_e <= 1'b0;
		end else if (en) begin
			v_d <= in_valid;
			v_e <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_d <= in_side.spread0;
			pd_d <= 64'(in_side.d * $signed({1'b0, cdf}));
			ps_d <= 64'(in_side.s * $signed({1'b0, den}));
		end
	end

	always_comb begin
		acc = pd_d + ps_d + 64'sd536870912;
		rr  = 34'(acc >>> 30);
		if (rr > 34'sd2147483647) sat = 32'sh7fff_ffff;
		else if (rr < -34'sd2147483648) sat = 32'sh8000_0000;
		else sat = rr[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_e  <= sp_d;
			imp_e <= sp_d ? 32'sd0 : sat;
		end
	end

	assign valid       = v_e;
	assign improvement = imp_e;
	assign no_spread   = sp_e;
endmodule

[design/gaussian_expected_improvement.sv]
// Expected improvement of a Gaussian prediction: fully pipelined, one word accepted
// per cycle while the pipe is not held (2 setup stages, 28 stages of the
// bit-per-stage divider that forms 10*|z|, 3 table/interpolation stages, 2 product
// and rounding stages, the last being the output register). The whole pipe holds
// while a result waits and the sink is not ready; empty slots still move, so the
// input stays ready until a valid word reaches the output.
module gaussian_expected_improvement #(
	parameter int CDF_ENTRIES = gei_pkg::CDF_ENTRIES
) (
	input  logic      clk,
	input  logic      arst_n,
	gei_in_if.sink    din,
	gei_out_if.source dout
);
	import gei_pkg::*;

	logic          en;
	logic          v_f, v_dv, v_l, v_o;
	gei_side_t     side_f, side_dv, side_l;
	logic [31:0]   rem0;
	logic [QB-1:0] nlow, quo;
	tab_t          cdf, den;

	assign en        = !v_o || dout.ready;
	assign din.ready = en;

	gei_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(din.valid),
		.prediction(din.prediction), .best_value(din.best_value),
		.deviation(din.deviation), .valid(v_f), .side(side_f),
		.rem0(rem0), .nlow(nlow)
	);

	gei_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_f), .in_side(side_f),
		.rem0(rem0), .nlow(nlow), .valid(v_dv), .side(side_dv), .quo(quo)
	);

	gei_lut #(.CDF_ENTRIES(CDF_ENTRIES)) u_lut (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_dv), .in_side(side_dv),
		.quo(quo), .valid(v_l), .side(side_l), .cdf(cdf), .den(den)
	);

	gei_comb u_comb (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_l), .in_side(side_l),
		.cdf(cdf), .den(den), .valid(v_o), .improvement(dout.improvement),
		.no_spread(dout.no_spread)
	);

	assign dout.valid = v_o;
endmodule

[bench/gaussian_expected_improvement_tb.sv]
// Testbench for the expected improvement pipeline: scoreboard, stimulus and idling phases
module gaussian_expected_improvement_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gei_pkg::*;

	typedef struct {
		logic signed [31:0] improvement;
		logic               no_spread;
	} ei_word_t;

	class ei_scoreboard;
		ei_word_t pending[$];
		int       errors;
		longint unsigned cdf_q[TAB_LEN];
		longint unsigned den_q[TAB_LEN];

		function new();
			errors = 0;
			for (int i = 0; i < TAB_LEN; i++) begin
				cdf_q[i] = (CDF_NANO[i] * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
				den_q[i] = (DEN_NANO[i] * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
			end
		endfunction

		function longint unsigned cdf_entry(longint unsigned i);
			return (i < TAB_LEN) ? cdf_q[i] : 64'h4000_0000;
		endfunction

		function longint unsigned den_entry(longint unsigned i);
			return (i < TAB_LEN) ? den_q[i] : 64'd0;
		endfunction

		function longint unsigned blend(longint unsigned a, longint unsigned b,
				longint unsigned frac);
			return (a * ((64'd1 << ZF) - frac) + b * frac) >> ZF;
		endfunction

		function ei_word_t improvement_of(logic signed [31:0] pred, logic signed [31:0] best,
				logic signed [31:0] dev);
			ei_word_t r;
			longint d, s, acc, q;
			longint unsigned mag, t, idx, frac, cm, cdf, den;
			r.no_spread = 1'b0;
			if (dev <= 0) begin
				r.improvement = '0;
				r.no_spread = 1'b1;
				return r;
			end
			d = longint'(best) - longint'(pred);
			s = dev;
			mag = (d < 0) ? -d : d;
			if (mag > 13 * s) t = 64'd127 << ZF;
			else t = ((mag * 10) << ZF) / s;
			idx = t >> ZF;
			frac = t & ((64'd1 << ZF) - 1);
			if (idx >= CDF_ENTRIES - 1) cm = cdf_entry(CDF_ENTRIES - 1);
			else cm = blend(cdf_entry(idx), cdf_entry(idx + 1), frac);
			if (idx >= TAB_LEN - 1) den = 0;
			else den = blend(den_entry(idx), den_entry(idx + 1), frac);
			if (mag > 7 * s) cdf = (d < 0) ? 0 : 64'h4000_0000;
			else cdf = (d < 0) ? 64'h4000_0000 - cm : cm;
			acc = d * longint'(cdf) + s * longint'(den);
			q = (acc + (64'sd1 <<< 29)) >>> 30;  // floor via arithmetic shift
			if (q > 64'sd2147483647) q = 64'sd2147483647;
			if (q < -64'sd2147483648) q = -64'sd2147483648;
			r.improvement = q[31:0];
			return r;
		endfunction

		function void note_input(logic signed [31:0] p, logic signed [31:0] b,
				logic signed [31:0] s);
			pending.push_back(improvement_of(p, b, s));
		endfunction

		function void check_result(logic signed [31:0] imp, logic ns);
			ei_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word imp=%0d no_spread=%0b", $time, imp, ns);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (imp !== e.improvement) begin
				$display("%0t: improvement expected %0d actual %0d", $time, e.improvement, imp);
				errors++;
			end
			if (ns !== e.no_spread) begin
				$display("%0t: no_spread expected %0b actual %0b", $time, e.no_spread, ns);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	gei_in_if  din();
	gei_out_if dout();

	gaussian_expected_improvement DUT (.clk(clk), .arst_n(arst_n), .din(din), .dout(dout));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	ei_scoreboard board = new();
	int send_idle = 0;   // percent
	int recv_stall = 0;  // percent
	int hold_cycles = 0;

	initial begin
		din.valid = 0;
		din.prediction = '0;
		din.best_value = '0;
		din.deviation = '0;
		dout.ready = 0;
	end

	// receiver: random stall, plus a long hold-off when requested
	always @(posedge clk) begin
		if (arst_n) begin
			if (dout.valid && dout.ready) board.check_result(dout.improvement, dout.no_spread);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	task automatic send_word(logic signed [31:0] p, logic signed [31:0] b,
			logic signed [31:0] s);
		while ($urandom_range(99) < send_idle) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.prediction <= p;
		din.best_value <= b;
		din.deviation <= s;
		do @(posedge clk); while (!din.ready);
		board.note_input(p, b, s);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0010_0000);
			2: return -$signed($urandom_range(32'h0010_0000));
			default: return $urandom_range(32'h7fff) << $urandom_range(20);
		endcase
	endfunction

	// random point around a chosen z so the whole table is swept, or random words
	task automatic send_random();
		logic signed [31:0] p, b, s;
		longint dl;
		int mode;
		mode = $urandom_range(9);
		if (mode < 6) begin
			s = $urandom_range(32'h0400_0000, 1);
			p = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
			dl = (longint'(s) * ($signed($urandom_range(160)) - 80)) / 10
				+ $signed($urandom_range(64)) - 32;
			dl = dl + longint'(p);
			if (dl > 64'sd2147483647) dl = 64'sd2147483647;
			if (dl < -64'sd2147483648) dl = -64'sd2147483648;
			b = dl[31:0];
		end else if (mode < 8) begin
			p = rand_word(); b = rand_word(); s = rand_word();
		end else begin
			p = $urandom; b = $urandom; s = $urandom;
		end
		send_word(p, b, s);
	endtask

	task automatic drain();
		din.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, no spread, zero z, clamps, far z, saturation
		send_word(0, 0, 0);
		send_word(32'sh0001_0000, 0, -1);
		send_word(0, 0, 32'sh8000_0000);
		send_word(0, 0, 32'sh0001_0000);
		send_word(32'sh7fff_ffff, 32'sh8000_0000, 1);
		send_word(32'sh8000_0000, 32'sh7fff_ffff, 1);
		send_word(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_word(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		send_word(0, 32'sh0007_0000, 32'sh0001_0000);
		send_word(0, 32'sh0007_0001, 32'sh0001_0000);
		send_word(32'sh0007_0001, 0, 32'sh0001_0000);
		send_word(0, 32'sh000d_0000, 32'sh0001_0000);
		send_word(0, 32'sh000d_0001, 32'sh0001_0000);
		send_word(0, 32'sh0007_8000, 32'sh0001_0000);
		send_word(0, 32'sh0000_8000, 32'sh0001_0000);
		send_word(32'sh0000_8000, 0, 32'sh0001_0000);
		send_word(32'shffff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_word(5, 5, 32'sh7fff_ffff);
		send_word(0, 32'sh0000_1999, 32'sh0001_0000);
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 81; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 81; end
				3: begin send_idle = 11; recv_stall = 11; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			if (ph == 4) hold_cycles = 150;  // pipe fills and input stalls
			for (int i = 0; i < 326; i++) send_random();
			drain();
		end
		if (board.errors == 0) $display("gaussian_expected_improvement_tb OK");
		else $display("gaussian_expected_improvement_tb NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("gaussian_expected_improvement_tb NOT OK");
		$finish;
	end
endmodule
